// File: design/assert_macros.svh
// Assertion helpers used by the bin packer checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define BPF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bin packer assertion failed");

// Condition must never be seen outside reset.
`define BPF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bin packer forbidden condition seen");

`endif

// File: design/bpf_pkg.sv
package bpf_pkg;

  localparam int unsigned NUM_BINS_DEF   = 64;
  localparam int unsigned FILL_WIDTH_DEF = 24;

  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned CAP_W      = 24;
  localparam int unsigned OUT_IDX_W  = 6;
  localparam int unsigned OUT_FILL_W = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CAP_W-1:0] CAP_RESET    = 24'd2000000;
  localparam logic             POLICY_RESET = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_CAPACITY = 1'b1;

  // input modes
  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // fit policies
  localparam logic POLICY_FIRST = 1'b0;
  localparam logic POLICY_BEST  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] item_size;
  } in_item_t;

  typedef struct packed {
    logic                  placed;
    logic [OUT_IDX_W-1:0]  bin_index;
    logic [OUT_FILL_W-1:0] bin_fill;
  } out_item_t;

  typedef struct packed {
    logic cnt_clr;
    logic cnt_inc;
    logic mem_rd;
    logic mem_clr_wr;
    logic load_item;
    logic res_zero;
    logic write_back;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } dp_status_t;

endpackage

// File: design/bpf_datapath.sv
module bpf_datapath #(
  parameter int unsigned NUM_BINS   = bpf_pkg::NUM_BINS_DEF,
  parameter int unsigned FILL_WIDTH = bpf_pkg::FILL_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bpf_pkg::ctrl_cmd_t                  cmd_i,
  output bpf_pkg::dp_status_t                 status_o,
  input  bpf_pkg::in_item_t                   in_data_i,
  output bpf_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bpf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import bpf_pkg::*;

  localparam int unsigned IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned SW = ((FILL_WIDTH > SIZE_W) ? FILL_WIDTH : SIZE_W) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BINS - 1);

  logic [FILL_WIDTH-1:0] mem_q [NUM_BINS];

  logic [IW-1:0]         cnt_q, cnt_d;
  logic [IW-1:0]         rd_idx_q;
  logic                  rd_vld_q;
  logic [FILL_WIDTH-1:0] rd_data_q;
  logic [SIZE_W-1:0]     size_q;
  logic                  found_q, found_d;
  logic [IW-1:0]         best_idx_q, best_idx_d;
  logic [FILL_WIDTH-1:0] best_fill_q, best_fill_d;
  logic                  policy_q;
  logic [CAP_W-1:0]      cap_q;
  out_item_t             res_q;
  out_item_t             out_q;

  logic [SW-1:0]         sum;
  logic                  fits;
  logic                  take;
  logic [SW-1:0]         nf_wide;
  logic [FILL_WIDTH-1:0] nf;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [FILL_WIDTH-1:0] wr_data;

  // fit test at full precision, one bin per cycle
  assign sum  = SW'(rd_data_q) + SW'(size_q);
  assign fits = sum < SW'(cap_q);
  assign take = rd_vld_q && fits &&
                (!found_q || (policy_q == POLICY_BEST && rd_data_q > best_fill_q));

  always_comb begin
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_fill_d = best_fill_q;
    if (cmd_i.load_item) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d     = 1'b1;
      best_idx_d  = rd_idx_q;
      best_fill_d = rd_data_q;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
    end
  end

  assign nf_wide = SW'(best_fill_q) + SW'(size_q);
  assign nf      = nf_wide[FILL_WIDTH-1:0];

  assign wr_en   = cmd_i.mem_clr_wr || (cmd_i.write_back && found_q);
  assign wr_addr = cmd_i.mem_clr_wr ? cnt_q : best_idx_q;
  assign wr_data = cmd_i.mem_clr_wr ? '0 : nf;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem_q[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      policy_q <= POLICY_RESET;
      cap_q    <= CAP_RESET;
    end else begin
      cnt_q    <= cnt_d;
      rd_vld_q <= cmd_i.mem_rd;
      found_q  <= found_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FIT_POLICY:   policy_q <= cfg_wdata_i[0];
          REG_BIN_CAPACITY: cap_q    <= cfg_wdata_i[CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= cnt_q;
    best_idx_q  <= best_idx_d;
    best_fill_q <= best_fill_d;
    if (cmd_i.load_item) begin
      size_q <= in_data_i.item_size;
    end
    if (cmd_i.res_zero) begin
      res_q <= '0;
    end else if (cmd_i.write_back) begin
      res_q.placed    <= found_q;
      res_q.bin_index <= found_q ? OUT_IDX_W'(best_idx_q) : '0;
      res_q.bin_fill  <= found_q ? OUT_FILL_W'(nf) : '0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign status_o.cnt_last = (cnt_q == LAST_IDX);
  assign out_data_o        = out_q;

endmodule

// File: design/bpf_ctrl.sv
module bpf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_mode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpf_pkg::ctrl_cmd_t  cmd_o,
  input  bpf_pkg::dp_status_t status_i
);
  import bpf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_TAIL  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  logic      reply_q, reply_d;
  logic      out_valid_q, out_valid_d;
  ctrl_cmd_t cmd;

  always_comb begin
    state_d    = state_q;
    reply_d    = reply_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.cnt_clr = 1'b1;
          if (in_mode_i == MODE_CLEAR) begin
            cmd.res_zero = 1'b1;
            reply_d      = 1'b1;
            state_d      = ST_CLEAR;
          end else begin
            cmd.load_item = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        cmd.mem_clr_wr = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (status_i.cnt_last) begin
          state_d = reply_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.mem_rd  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_TAIL;
        end
      end
      // last read beat is compared here
      ST_TAIL: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write_back = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // reset starts with a clearing sweep that sends no beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reply_q     <= reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

// File: design/bin_packing_fit_allocator.sv
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i/in_ready_o  | in_item_t: mode, item_size
// out     | output    | out_valid_o/out_ready_i| out_item_t: placed, bin_index, bin_fill
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A placement runs from one accepted beat to the next through the accept, one bin fill
// read per cycle, a tail state for the last read, a write-back and an output load.
// A clear zeroes the fill memory one entry per cycle.
// After reset the same clearing pass runs before in_ready_o rises.
// One item is in flight at a time; a held output beat parks the next result and keeps
// in_ready_o low until it leaves.
module bin_packing_fit_allocator #(
  parameter int unsigned NUM_BINS   = bpf_pkg::NUM_BINS_DEF,
  parameter int unsigned FILL_WIDTH = bpf_pkg::FILL_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bpf_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bpf_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bpf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mode_i   (in_data_i.mode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  bpf_datapath #(
    .NUM_BINS   (NUM_BINS),
    .FILL_WIDTH (FILL_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

// File: design/bpf_checker.sv
`include "assert_macros.svh"

module bpf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input bpf_pkg::in_item_t              in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input bpf_pkg::out_item_t             out_data_o,
  input logic                           cfg_we_i,
  input logic [bpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [bpf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bpf_pkg::*;

  // a stalled result beat holds
  `BPF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // an unplaced result carries no bin and no fill
  `BPF_ASSERT(a_unplaced_zero, clk_i, rst_ni, out_valid_o && !out_data_o.placed |-> out_data_o.bin_index == '0 && out_data_o.bin_fill == '0)

  // one item at a time: input closes right after an accepted beat
  `BPF_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // an accepted beat never turns into a result in the next cycle
  `BPF_ASSERT_NEVER(a_no_instant_result, clk_i, rst_ni, $past(in_valid_i && in_ready_o) && $rose(out_valid_o))

endmodule

bind bin_packing_fit_allocator bpf_checker u_bpf_checker (.*);
